[rtl/postfix_stack_evaluator_top_defines.svh]
// Assertion helpers for the evaluator top module.
`ifndef POSTFIX_STACK_EVALUATOR_TOP_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, idle while reset is high.
`define PSEV_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PSEV_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/psev_pkg.sv]
`default_nettype none
package psev_pkg;

   localparam int DATA_W          = 32;
   localparam int OPC_W           = 3;
   localparam int ERR_W           = 3;
   localparam int STACK_DEPTH_DEF = 64;

   typedef enum logic [OPC_W-1:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_REM  = 3'd5
   } opcode_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 3'd0,
      ERR_MISSING  = 3'd1,
      ERR_LEFTOVER = 3'd2,
      ERR_DIVZERO  = 3'd3,
      ERR_OVERFLOW = 3'd4
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_RIGHT,
      ST_RD_LEFT,
      ST_EXEC,
      ST_FINISH,
      ST_FIN_RD
   } state_type;

   typedef enum logic [1:0] {
      ALU_IDLE,
      ALU_DIV,
      ALU_FIX
   } alu_phase_type;

   typedef struct packed {
      logic       start;
      opcode_type op;
   } alu_req_type;

   typedef struct packed {
      logic done;
      logic div_zero;
   } alu_rsp_type;

endpackage
`default_nettype wire

[rtl/psev_if.sv]
`default_nettype none
interface psev_req_if;
   logic                            valid;
   logic                            ready;
   logic [psev_pkg::OPC_W-1:0]      opcode;
   logic signed [psev_pkg::DATA_W-1:0] operand_value;
   logic                            last_token;

   modport source (output valid, output opcode, output operand_value, output last_token,
                   input ready);
   modport sink   (input valid, input opcode, input operand_value, input last_token,
                   output ready);
endinterface

interface psev_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [psev_pkg::DATA_W-1:0] result_value;
   logic [psev_pkg::ERR_W-1:0]      error_code;

   modport source (output valid, output result_value, output error_code, input ready);
   modport sink   (input valid, input result_value, input error_code, output ready);
endinterface
`default_nettype wire

[rtl/psev_alu.sv]
`default_nettype none
module psev_alu (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire psev_pkg::alu_req_type         alu_req,
   input  wire logic [psev_pkg::DATA_W-1:0]   left,
   input  wire logic [psev_pkg::DATA_W-1:0]   right,
   output psev_pkg::alu_rsp_type              alu_rsp,
   output logic [psev_pkg::DATA_W-1:0]        result
);

   localparam int W   = psev_pkg::DATA_W;
   localparam int CW  = $clog2(W);

   psev_pkg::alu_phase_type phase_ff, phase_in;
   logic [CW-1:0] cnt_ff;
   logic [W-1:0]  quo_ff, rem_ff, dvs_ff, result_ff;
   logic          neg_q_ff, neg_r_ff, rem_sel_ff, done_ff, dz_ff;

   logic [W:0]    trial;
   logic [W-1:0]  abs_left, abs_right;

   assign abs_left  = left[W-1]  ? (~left + W'(1))  : left;
   assign abs_right = right[W-1] ? (~right + W'(1)) : right;
   // restoring step: shift in next dividend bit, try subtracting divisor
   assign trial     = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         psev_pkg::ALU_IDLE: begin
            if (alu_req.start && (alu_req.op == psev_pkg::OP_DIV ||
                                  alu_req.op == psev_pkg::OP_REM) && right != '0)
               phase_in = psev_pkg::ALU_DIV;
         end
         psev_pkg::ALU_DIV: begin
            if (cnt_ff == CW'(W - 1))
               phase_in = psev_pkg::ALU_FIX;
         end
         psev_pkg::ALU_FIX: phase_in = psev_pkg::ALU_IDLE;
         default:           phase_in = psev_pkg::ALU_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= psev_pkg::ALU_IDLE;
         done_ff  <= 1'b0;
         dz_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= 1'b0;
         case (phase_ff)
            psev_pkg::ALU_IDLE: begin
               if (alu_req.start) begin
                  dz_ff <= 1'b0;
                  case (alu_req.op)
                     psev_pkg::OP_ADD: begin
                        result_ff <= left + right;
                        done_ff   <= 1'b1;
                     end
                     psev_pkg::OP_SUB: begin
                        result_ff <= left - right;
                        done_ff   <= 1'b1;
                     end
                     psev_pkg::OP_MUL: begin
                        result_ff <= left * right;
                        done_ff   <= 1'b1;
                     end
                     default: begin
                        if (right == '0) begin
                           dz_ff     <= 1'b1;
                           result_ff <= '0;
                           done_ff   <= 1'b1;
                        end
                     end
                  endcase
               end
            end
            psev_pkg::ALU_FIX: begin
               // quotient sign from both operands, remainder follows the dividend
               if (rem_sel_ff)
                  result_ff <= neg_r_ff ? (~rem_ff + W'(1)) : rem_ff;
               else
                  result_ff <= neg_q_ff ? (~quo_ff + W'(1)) : quo_ff;
               done_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // divide set-up and steps, payload only
   always_ff @(posedge clock) begin
      if (phase_ff == psev_pkg::ALU_IDLE && alu_req.start) begin
         quo_ff     <= abs_left;
         rem_ff     <= '0;
         dvs_ff     <= abs_right;
         neg_q_ff   <= left[W-1] ^ right[W-1];
         neg_r_ff   <= left[W-1];
         rem_sel_ff <= (alu_req.op == psev_pkg::OP_REM);
         cnt_ff     <= '0;
      end else if (phase_ff == psev_pkg::ALU_DIV) begin
         if (!trial[W]) begin
            rem_ff <= trial[W-1:0];
            quo_ff <= {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[W-2:0], quo_ff[W-1]};
            quo_ff <= {quo_ff[W-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + CW'(1);
      end
   end

   assign alu_rsp.done     = done_ff;
   assign alu_rsp.div_zero = dz_ff;
   assign result           = result_ff;

endmodule
`default_nettype wire

[rtl/postfix_stack_evaluator_top.sv]
// Push token: the next transaction can be taken in the following cycle.
// Add, subtract, multiply: two reads on the single stack RAM read port, then the ALU result.
// Divide, remainder: bit-serial divider (32 steps plus sign fix); a zero divisor skips it.
// Last token: bottom entry read, then loaded into the result register, which holds until taken.
// Synchronous active-high reset clears the sequencer, depth, error and result valid;
// stack RAM contents are not cleared and need no clearing pass.
`default_nettype none
`include "postfix_stack_evaluator_top_defines.svh"
module postfix_stack_evaluator_top #(
   parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   psev_req_if.sink   req_if,
   psev_rsp_if.source rsp_if
);

   localparam int W     = psev_pkg::DATA_W;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);

   psev_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   psev_pkg::err_type    error_ff, error_in;
   psev_pkg::opcode_type op_ff;
   logic                 last_ff;
   logic [W-1:0]         right_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]         rsp_value_ff;
   psev_pkg::err_type    rsp_error_ff, rsp_error_in;

   logic [W-1:0]         mem [STACK_DEPTH];
   logic [W-1:0]         rd_ff;
   logic                 wr_en, rd_en;
   logic [IDX_W-1:0]     wr_addr, rd_addr;
   logic [W-1:0]         wr_data;

   logic                 accept, is_operator, rsp_load, rsp_free;
   logic [CNT_W-1:0]     cnt_m1, cnt_m2;

   psev_pkg::alu_req_type alu_req;
   psev_pkg::alu_rsp_type alu_rsp;
   logic [W-1:0]          alu_result;

   psev_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .left    (rd_ff),
      .right   (right_ff),
      .alu_rsp (alu_rsp),
      .result  (alu_result)
   );

   assign req_if.ready = (state_ff == psev_pkg::ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign is_operator  = req_if.opcode inside {[psev_pkg::OP_ADD:psev_pkg::OP_REM]};
   assign cnt_m1       = count_ff - CNT_W'(1);
   assign cnt_m2       = count_ff - CNT_W'(2);
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psev_pkg::ST_IDLE: begin
            if (accept) begin
               if (error_ff == psev_pkg::ERR_NONE && is_operator && count_ff >= CNT_W'(2))
                  state_in = psev_pkg::ST_RD_RIGHT;
               else if (req_if.last_token)
                  state_in = psev_pkg::ST_FINISH;
            end
         end
         psev_pkg::ST_RD_RIGHT: state_in = psev_pkg::ST_RD_LEFT;
         psev_pkg::ST_RD_LEFT:  state_in = psev_pkg::ST_EXEC;
         psev_pkg::ST_EXEC: begin
            if (alu_rsp.done)
               state_in = last_ff ? psev_pkg::ST_FINISH : psev_pkg::ST_IDLE;
         end
         psev_pkg::ST_FINISH: state_in = psev_pkg::ST_FIN_RD;
         psev_pkg::ST_FIN_RD: begin
            if (rsp_free)
               state_in = psev_pkg::ST_IDLE;
         end
         default: state_in = psev_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      count_in      = count_ff;
      error_in      = error_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = req_if.operand_value;
      rd_en         = 1'b0;
      rd_addr       = cnt_m1[IDX_W-1:0];
      alu_req.start = 1'b0;
      alu_req.op    = op_ff;
      rsp_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_error_in  = error_ff;
      case (state_ff)
         psev_pkg::ST_IDLE: begin
            if (accept && error_ff == psev_pkg::ERR_NONE) begin
               if (req_if.opcode == psev_pkg::OP_PUSH) begin
                  if (count_ff == CNT_W'(STACK_DEPTH)) begin
                     error_in = psev_pkg::ERR_OVERFLOW;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (is_operator) begin
                  if (count_ff < CNT_W'(2))
                     error_in = psev_pkg::ERR_MISSING;
                  else
                     rd_en = 1'b1;
               end
            end
         end
         psev_pkg::ST_RD_RIGHT: begin
            rd_en   = 1'b1;
            rd_addr = cnt_m2[IDX_W-1:0];
         end
         psev_pkg::ST_RD_LEFT: begin
            alu_req.start = 1'b1;
         end
         psev_pkg::ST_EXEC: begin
            if (alu_rsp.done) begin
               if (alu_rsp.div_zero) begin
                  error_in = psev_pkg::ERR_DIVZERO;
                  count_in = cnt_m2;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = cnt_m2[IDX_W-1:0];
                  wr_data  = alu_result;
                  count_in = cnt_m1;
               end
            end
         end
         psev_pkg::ST_FINISH: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         psev_pkg::ST_FIN_RD: begin
            if (rsp_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (error_ff == psev_pkg::ERR_NONE) begin
                  if (count_ff == '0)
                     rsp_error_in = psev_pkg::ERR_MISSING;
                  else if (count_ff > CNT_W'(1))
                     rsp_error_in = psev_pkg::ERR_LEFTOVER;
                  else
                     rsp_error_in = psev_pkg::ERR_NONE;
               end
               count_in = '0;
               error_in = psev_pkg::ERR_NONE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psev_pkg::ST_IDLE;
         count_ff     <= '0;
         error_ff     <= psev_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= psev_pkg::opcode_type'(req_if.opcode);
         last_ff <= req_if.last_token;
      end
      if (state_ff == psev_pkg::ST_RD_RIGHT)
         right_ff <= rd_ff;
      if (rsp_load) begin
         rsp_error_ff <= rsp_error_in;
         rsp_value_ff <= (rsp_error_in == psev_pkg::ERR_NONE) ? rd_ff : '0;
      end
   end

   // stack RAM, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_ff <= mem[rd_addr];
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_value = rsp_value_ff;
   assign rsp_if.error_code   = rsp_error_ff;

   `PSEV_ASSERT_IMP(a_err_zero_value, rsp_valid_ff && rsp_error_ff != psev_pkg::ERR_NONE, rsp_value_ff == '0, "errored result carries a non-zero value")
   `PSEV_ASSERT_NXT(a_last_busy, accept && req_if.last_token, !req_if.ready, "ready high straight after a last token")
   `PSEV_ASSERT_IMP(a_alu_done_exec, alu_rsp.done, state_ff == psev_pkg::ST_EXEC, "ALU completion outside execute")
   `PSEV_ASSERT_IMP(a_depth_bound, state_ff == psev_pkg::ST_IDLE, count_ff <= CNT_W'(STACK_DEPTH), "stack depth beyond capacity")

endmodule
`default_nettype wire
